// ----- rtl/iie_pkg.sv -----
package iie_pkg;

    // Field widths of one request and one result.
    localparam int unsigned INSTR_W = 32;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned OPC_W   = 6;
    localparam int unsigned IMM_W   = 16;
    localparam int unsigned JIDX_W  = 26;

    // Primary opcodes.
    localparam logic [OPC_W-1:0] OP_SPECIAL = 6'h00;
    localparam logic [OPC_W-1:0] OP_REGIMM  = 6'h01;
    localparam logic [OPC_W-1:0] OP_J       = 6'h02;
    localparam logic [OPC_W-1:0] OP_JAL     = 6'h03;
    localparam logic [OPC_W-1:0] OP_BEQ     = 6'h04;
    localparam logic [OPC_W-1:0] OP_BNE     = 6'h05;
    localparam logic [OPC_W-1:0] OP_BLEZ    = 6'h06;
    localparam logic [OPC_W-1:0] OP_BGTZ    = 6'h07;
    localparam logic [OPC_W-1:0] OP_ADDI    = 6'h08;
    localparam logic [OPC_W-1:0] OP_ADDIU   = 6'h09;
    localparam logic [OPC_W-1:0] OP_SLTI    = 6'h0A;
    localparam logic [OPC_W-1:0] OP_SLTIU   = 6'h0B;
    localparam logic [OPC_W-1:0] OP_ANDI    = 6'h0C;
    localparam logic [OPC_W-1:0] OP_ORI     = 6'h0D;
    localparam logic [OPC_W-1:0] OP_XORI    = 6'h0E;
    localparam logic [OPC_W-1:0] OP_LUI     = 6'h0F;
    localparam logic [OPC_W-1:0] OP_COP0    = 6'h10;
    localparam logic [OPC_W-1:0] OP_COP1    = 6'h11;
    localparam logic [OPC_W-1:0] OP_COP2    = 6'h12;
    localparam logic [OPC_W-1:0] OP_BEQL    = 6'h14;
    localparam logic [OPC_W-1:0] OP_BNEL    = 6'h15;
    localparam logic [OPC_W-1:0] OP_DADDIU  = 6'h19;
    localparam logic [OPC_W-1:0] OP_MMI     = 6'h1C;
    localparam logic [OPC_W-1:0] OP_LQ      = 6'h1E;
    localparam logic [OPC_W-1:0] OP_SQ      = 6'h1F;
    localparam logic [OPC_W-1:0] OP_LB      = 6'h20;
    localparam logic [OPC_W-1:0] OP_LH      = 6'h21;
    localparam logic [OPC_W-1:0] OP_LW      = 6'h23;
    localparam logic [OPC_W-1:0] OP_LBU     = 6'h24;
    localparam logic [OPC_W-1:0] OP_LHU     = 6'h25;
    localparam logic [OPC_W-1:0] OP_LWU     = 6'h27;
    localparam logic [OPC_W-1:0] OP_SB      = 6'h28;
    localparam logic [OPC_W-1:0] OP_SH      = 6'h29;
    localparam logic [OPC_W-1:0] OP_SW      = 6'h2B;
    localparam logic [OPC_W-1:0] OP_CACHE   = 6'h2F;
    localparam logic [OPC_W-1:0] OP_LD      = 6'h37;
    localparam logic [OPC_W-1:0] OP_SWC1    = 6'h39;
    localparam logic [OPC_W-1:0] OP_SD      = 6'h3F;

    // Address masks and the link register.
    localparam logic [ADDR_W-1:0] JUMP_REGION_MASK = 32'hF000_0000;
    localparam logic [ADDR_W-1:0] QUAD_ALIGN_MASK  = 32'hFFFF_FFF0;
    localparam logic [ADDR_W-1:0] LINK_OFFSET      = 32'd4;
    localparam logic [REG_W-1:0]  LINK_REG         = 5'd31;

    typedef enum logic [1:0] {
        ST_EXEC    = 2'd0,
        ST_DELEGATE = 2'd1,
        ST_NOP     = 2'd2,
        ST_ILLEGAL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MEM_NONE   = 2'd0,
        MEM_LOAD_S = 2'd1,
        MEM_LOAD_U = 2'd2,
        MEM_STORE  = 2'd3
    } t_mem_op;

    typedef enum logic [2:0] {
        SZ_BYTE   = 3'd0,
        SZ_HALF   = 3'd1,
        SZ_WORD   = 3'd2,
        SZ_DOUBLE = 3'd3,
        SZ_QUAD   = 3'd4
    } t_mem_size;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_ADD32,
        ALU_ADD64,
        ALU_SLT,
        ALU_SLTU,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_LUI,
        ALU_LINK
    } t_alu;

    typedef enum logic [2:0] {
        BR_NONE,
        BR_JUMP,
        BR_EQ,
        BR_NE,
        BR_LEZ,
        BR_GTZ
    } t_branch;

    typedef enum logic [1:0] {
        DEST_NONE,
        DEST_RT,
        DEST_LINK
    } t_dest;

    // Control word from the decoder to the datapath.
    typedef struct packed {
        t_status   status;
        t_alu      alu;
        t_branch   branch;
        logic      likely;
        t_dest     dest;
        t_mem_op   mem_op;
        t_mem_size mem_size;
    } t_ctrl;

    // One result, as held in the result register.
    typedef struct packed {
        logic              write_enable;
        logic [REG_W-1:0]  dest_reg;
        logic [DATA_W-1:0] write_value;
        logic              branch_taken;
        logic [ADDR_W-1:0] branch_target;
        logic              skip_slot;
        t_mem_op           mem_op;
        t_mem_size         mem_size;
        logic [ADDR_W-1:0] mem_address;
        logic [DATA_W-1:0] store_low;
        logic [DATA_W-1:0] store_high;
        t_status           status;
    } t_result;

endpackage

// ----- rtl/iie_if.sv -----
// Request channel: one instruction with its operands.
interface iie_req_if;
    import iie_pkg::*;

    logic              valid;
    logic              ready;
    logic [INSTR_W-1:0] instr;
    logic [ADDR_W-1:0] next_addr;
    logic [DATA_W-1:0] src_value;
    logic [DATA_W-1:0] tgt_value;
    logic [DATA_W-1:0] tgt_upper;

    modport source (
        output valid, instr, next_addr, src_value, tgt_value, tgt_upper,
        input  ready
    );
    modport sink (
        input  valid, instr, next_addr, src_value, tgt_value, tgt_upper,
        output ready
    );
endinterface

// Result channel: writeback, branch and memory request of one instruction.
interface iie_res_if;
    import iie_pkg::*;

    logic              valid;
    logic              ready;
    logic              write_enable;
    logic [REG_W-1:0]  dest_reg;
    logic [DATA_W-1:0] write_value;
    logic              branch_taken;
    logic [ADDR_W-1:0] branch_target;
    logic              skip_slot;
    logic [1:0]        mem_op;
    logic [2:0]        mem_size;
    logic [ADDR_W-1:0] mem_address;
    logic [DATA_W-1:0] store_low;
    logic [DATA_W-1:0] store_high;
    logic [1:0]        status;

    modport source (
        output valid, write_enable, dest_reg, write_value, branch_taken,
               branch_target, skip_slot, mem_op, mem_size, mem_address,
               store_low, store_high, status,
        input  ready
    );
    modport sink (
        input  valid, write_enable, dest_reg, write_value, branch_taken,
               branch_target, skip_slot, mem_op, mem_size, mem_address,
               store_low, store_high, status,
        output ready
    );
endinterface

// ----- rtl/iie_decode.sv -----
module iie_decode (
    input  logic [iie_pkg::OPC_W-1:0] i_opcode,
    output iie_pkg::t_ctrl            o_ctrl
);
    import iie_pkg::*;

    // Opcode to control word; anything not listed is illegal.
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.status   = ST_EXEC;
        o_ctrl.alu      = ALU_NONE;
        o_ctrl.branch   = BR_NONE;
        o_ctrl.likely   = 1'b0;
        o_ctrl.dest     = DEST_NONE;
        o_ctrl.mem_op   = MEM_NONE;
        o_ctrl.mem_size = SZ_BYTE;
        case (i_opcode)
            OP_SPECIAL, OP_REGIMM, OP_COP0, OP_COP1, OP_COP2, OP_MMI: begin
                o_ctrl.status = ST_DELEGATE;
            end
            OP_CACHE, OP_SWC1: begin
                o_ctrl.status = ST_NOP;
            end
            OP_J: begin
                o_ctrl.branch = BR_JUMP;
            end
            OP_JAL: begin
                o_ctrl.branch = BR_JUMP;
                o_ctrl.alu    = ALU_LINK;
                o_ctrl.dest   = DEST_LINK;
            end
            OP_BEQ:  o_ctrl.branch = BR_EQ;
            OP_BNE:  o_ctrl.branch = BR_NE;
            OP_BLEZ: o_ctrl.branch = BR_LEZ;
            OP_BGTZ: o_ctrl.branch = BR_GTZ;
            OP_BEQL: begin
                o_ctrl.branch = BR_EQ;
                o_ctrl.likely = 1'b1;
            end
            OP_BNEL: begin
                o_ctrl.branch = BR_NE;
                o_ctrl.likely = 1'b1;
            end
            OP_ADDI, OP_ADDIU: begin
                o_ctrl.alu  = ALU_ADD32;
                o_ctrl.dest = DEST_RT;
            end
            OP_SLTI: begin
                o_ctrl.alu  = ALU_SLT;
                o_ctrl.dest = DEST_RT;
            end
            OP_SLTIU: begin
                o_ctrl.alu  = ALU_SLTU;
                o_ctrl.dest = DEST_RT;
            end
            OP_ANDI: begin
                o_ctrl.alu  = ALU_AND;
                o_ctrl.dest = DEST_RT;
            end
            OP_ORI: begin
                o_ctrl.alu  = ALU_OR;
                o_ctrl.dest = DEST_RT;
            end
            OP_XORI: begin
                o_ctrl.alu  = ALU_XOR;
                o_ctrl.dest = DEST_RT;
            end
            OP_LUI: begin
                o_ctrl.alu  = ALU_LUI;
                o_ctrl.dest = DEST_RT;
            end
            OP_DADDIU: begin
                o_ctrl.alu  = ALU_ADD64;
                o_ctrl.dest = DEST_RT;
            end
            OP_LB, OP_LH, OP_LW, OP_LD, OP_LQ: begin
                o_ctrl.dest   = DEST_RT;
                o_ctrl.mem_op = MEM_LOAD_S;
                case (i_opcode)
                    OP_LB:   o_ctrl.mem_size = SZ_BYTE;
                    OP_LH:   o_ctrl.mem_size = SZ_HALF;
                    OP_LW:   o_ctrl.mem_size = SZ_WORD;
                    OP_LD:   o_ctrl.mem_size = SZ_DOUBLE;
                    default: o_ctrl.mem_size = SZ_QUAD;
                endcase
            end
            OP_LBU, OP_LHU, OP_LWU: begin
                o_ctrl.dest   = DEST_RT;
                o_ctrl.mem_op = MEM_LOAD_U;
                case (i_opcode)
                    OP_LBU:  o_ctrl.mem_size = SZ_BYTE;
                    OP_LHU:  o_ctrl.mem_size = SZ_HALF;
                    default: o_ctrl.mem_size = SZ_WORD;
                endcase
            end
            OP_SB, OP_SH, OP_SW, OP_SD, OP_SQ: begin
                o_ctrl.mem_op = MEM_STORE;
                case (i_opcode)
                    OP_SB:   o_ctrl.mem_size = SZ_BYTE;
                    OP_SH:   o_ctrl.mem_size = SZ_HALF;
                    OP_SW:   o_ctrl.mem_size = SZ_WORD;
                    OP_SD:   o_ctrl.mem_size = SZ_DOUBLE;
                    default: o_ctrl.mem_size = SZ_QUAD;
                endcase
            end
            default: begin
                o_ctrl.status = ST_ILLEGAL;
            end
        endcase
    end

endmodule

// ----- rtl/iie_exec.sv -----
module iie_exec (
    input  logic [iie_pkg::INSTR_W-1:0] i_instr,
    input  logic [iie_pkg::ADDR_W-1:0]  i_next_addr,
    input  logic [iie_pkg::DATA_W-1:0]  i_src_value,
    input  logic [iie_pkg::DATA_W-1:0]  i_tgt_value,
    input  logic [iie_pkg::DATA_W-1:0]  i_tgt_upper,
    input  iie_pkg::t_ctrl              i_ctrl,
    output iie_pkg::t_result            o_result
);
    import iie_pkg::*;

    logic [DATA_W-1:0] imm_s;
    logic [DATA_W-1:0] imm_z;
    logic [DATA_W-1:0] sum;
    logic [ADDR_W-1:0] eff_addr;
    logic [ADDR_W-1:0] br_target;
    logic [ADDR_W-1:0] jmp_target;
    logic [ADDR_W-1:0] link_addr;
    logic [REG_W-1:0]  rt;
    logic              src_zero;
    logic              cond;

    // Immediate forms and the shared adders.
    assign rt         = i_instr[20:16];
    assign imm_s      = {{(DATA_W-IMM_W){i_instr[IMM_W-1]}}, i_instr[IMM_W-1:0]};
    assign imm_z      = {{(DATA_W-IMM_W){1'b0}}, i_instr[IMM_W-1:0]};
    assign sum        = i_src_value + imm_s;
    assign eff_addr   = sum[ADDR_W-1:0];
    assign br_target  = i_next_addr + {imm_s[ADDR_W-3:0], 2'b00};
    assign jmp_target = (i_next_addr & JUMP_REGION_MASK) | {4'b0, i_instr[JIDX_W-1:0], 2'b00};
    assign link_addr  = i_next_addr + LINK_OFFSET;
    assign src_zero   = (i_src_value == '0);

    // Branch condition.
    always_comb begin
        case (i_ctrl.branch)
            BR_JUMP: cond = 1'b1;
            BR_EQ:   cond = (i_src_value == i_tgt_value);
            BR_NE:   cond = (i_src_value != i_tgt_value);
            BR_LEZ:  cond = i_src_value[DATA_W-1] || src_zero;
            BR_GTZ:  cond = !i_src_value[DATA_W-1] && !src_zero;
            default: cond = 1'b0;
        endcase
    end

    // Result assembly; fields that the instruction does not use stay zero.
    always_comb begin
        o_result        = '0;
        o_result.status = i_ctrl.status;
        o_result.mem_op = i_ctrl.mem_op;

        case (i_ctrl.alu)
            ALU_ADD32: o_result.write_value = {{(DATA_W-32){sum[31]}}, sum[31:0]};
            ALU_ADD64: o_result.write_value = sum;
            ALU_SLT:   o_result.write_value = {{(DATA_W-1){1'b0}},
                                              ($signed(i_src_value) < $signed(imm_s))};
            ALU_SLTU:  o_result.write_value = {{(DATA_W-1){1'b0}}, (i_src_value < imm_s)};
            ALU_AND:   o_result.write_value = i_src_value & imm_z;
            ALU_OR:    o_result.write_value = i_src_value | imm_z;
            ALU_XOR:   o_result.write_value = i_src_value ^ imm_z;
            ALU_LUI:   o_result.write_value = {{(DATA_W-32){i_instr[IMM_W-1]}},
                                              i_instr[IMM_W-1:0], {IMM_W{1'b0}}};
            ALU_LINK:  o_result.write_value = {{(DATA_W-ADDR_W){1'b0}}, link_addr};
            default:   o_result.write_value = '0;
        endcase
        o_result.write_enable = (i_ctrl.alu != ALU_NONE);

        case (i_ctrl.dest)
            DEST_RT:   o_result.dest_reg = rt;
            DEST_LINK: o_result.dest_reg = LINK_REG;
            default:   o_result.dest_reg = '0;
        endcase

        // Taken branches give a target; a likely branch not taken skips its slot.
        if (i_ctrl.branch != BR_NONE) begin
            if (cond) begin
                o_result.branch_taken  = 1'b1;
                o_result.branch_target = (i_ctrl.branch == BR_JUMP) ? jmp_target : br_target;
            end else begin
                o_result.skip_slot = i_ctrl.likely;
            end
        end

        // Memory request; quadword accesses are aligned to 16 bytes.
        if (i_ctrl.mem_op != MEM_NONE) begin
            o_result.mem_size    = i_ctrl.mem_size;
            o_result.mem_address = (i_ctrl.mem_size == SZ_QUAD) ?
                                   (eff_addr & QUAD_ALIGN_MASK) : eff_addr;
            if (i_ctrl.mem_op == MEM_STORE) begin
                o_result.store_low = i_tgt_value;
                if (i_ctrl.mem_size == SZ_QUAD) begin
                    o_result.store_high = i_tgt_upper;
                end
            end
        end
    end

endmodule

// ----- rtl/immediate_instruction_execute.sv -----
// Execute stage for primary-opcode instructions. A request is captured in the
// input register, decoded and executed combinationally, and the result is
// held in the result register; a request passes the input register and then
// the result register before its result is presented. One request is accepted
// every cycle as long as the result side takes one every cycle. Each register
// stage moves forward whenever the stage after it is empty or being emptied,
// so a stalled result holds its place while the request behind it waits in
// the input register.
module immediate_instruction_execute (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iie_req_if.sink       i_req,
    iie_res_if.source     o_res
);
    import iie_pkg::*;

    logic               r_in_valid;
    logic               n_in_valid;
    logic [INSTR_W-1:0] r_instr;
    logic [ADDR_W-1:0]  r_next_addr;
    logic [DATA_W-1:0]  r_src_value;
    logic [DATA_W-1:0]  r_tgt_value;
    logic [DATA_W-1:0]  r_tgt_upper;
    logic               r_out_valid;
    logic               n_out_valid;
    t_result            r_result;
    t_result            n_result;
    t_ctrl              ctrl;
    logic               out_free;
    logic               in_free;
    logic               in_take;
    logic               out_load;

    // Stage advance: each register takes new data when it is empty or draining.
    assign out_free = !r_out_valid || o_res.ready;
    assign out_load = r_in_valid && out_free;
    assign in_free  = !r_in_valid || out_free;
    assign in_take  = i_req.valid && in_free;
    assign i_req.ready = in_free;

    assign n_in_valid  = in_take || (r_in_valid && !out_free);
    assign n_out_valid = out_load || (r_out_valid && !o_res.ready);

    // Decode and execute the held request.
    iie_decode u_decode (
        .i_opcode (r_instr[INSTR_W-1 -: OPC_W]),
        .o_ctrl   (ctrl)
    );

    iie_exec u_exec (
        .i_instr     (r_instr),
        .i_next_addr (r_next_addr),
        .i_src_value (r_src_value),
        .i_tgt_value (r_tgt_value),
        .i_tgt_upper (r_tgt_upper),
        .i_ctrl      (ctrl),
        .o_result    (n_result)
    );

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_instr     <= i_req.instr;
            r_next_addr <= i_req.next_addr;
            r_src_value <= i_req.src_value;
            r_tgt_value <= i_req.tgt_value;
            r_tgt_upper <= i_req.tgt_upper;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_result <= n_result;
        end
    end

    // Result port.
    assign o_res.valid         = r_out_valid;
    assign o_res.write_enable  = r_result.write_enable;
    assign o_res.dest_reg      = r_result.dest_reg;
    assign o_res.write_value   = r_result.write_value;
    assign o_res.branch_taken  = r_result.branch_taken;
    assign o_res.branch_target = r_result.branch_target;
    assign o_res.skip_slot     = r_result.skip_slot;
    assign o_res.mem_op        = r_result.mem_op;
    assign o_res.mem_size      = r_result.mem_size;
    assign o_res.mem_address   = r_result.mem_address;
    assign o_res.store_low     = r_result.store_low;
    assign o_res.store_high    = r_result.store_high;
    assign o_res.status        = r_result.status;

    // A result that was not executed carries no side effects.
    a_not_exec_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.status != ST_EXEC) |->
        (!r_result.write_enable && !r_result.branch_taken &&
         r_result.mem_op == MEM_NONE))
        else $error("non-executed result has side effects");

    // A branch is either taken or has its slot skipped, never both.
    a_taken_or_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.branch_taken && r_result.skip_slot))
        else $error("branch taken and slot skipped together");

    // Quadword accesses are aligned to 16 bytes.
    a_quad_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.mem_size == SZ_QUAD) |->
        (r_result.mem_address[3:0] == 4'b0))
        else $error("quadword access not aligned");

    // An accepted request is held in the input register on the next cycle.
    a_req_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_in_valid)
        else $error("accepted request was lost");

endmodule
